// ===== rtl/core/sgcg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sgcg_pkg;

   // field widths
   localparam int CODE_W  = 8;
   localparam int ROW_W   = 2;
   localparam int ADDR_W  = 11;
   localparam int BYTE_W  = 8;
   localparam int SCALE_W = 3;
   localparam int CSR_IDX_W = 3;
   localparam int STORE_DEPTH = 2048;

   // opcodes
   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_RENDER = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_FIRST_CODE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LAST_CODE   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SUBST_INDEX = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_INDEX_OFFS  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_HSCALE      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_VSCALE      = 3'd5;

   // reset values
   localparam logic [CODE_W-1:0]  RST_FIRST_CODE  = 8'd32;
   localparam logic [CODE_W-1:0]  RST_LAST_CODE   = 8'd126;
   localparam logic [CODE_W-1:0]  RST_SUBST_INDEX = 8'd0;
   localparam logic [CODE_W-1:0]  RST_INDEX_OFFS  = 8'd225;
   localparam logic [SCALE_W-1:0] RST_HSCALE      = 3'd1;
   localparam logic [SCALE_W-1:0] RST_VSCALE      = 3'd1;

   // vertical scale codes
   localparam logic [SCALE_W-1:0] VSCALE_1 = 3'd1;
   localparam logic [SCALE_W-1:0] VSCALE_2 = 3'd2;
   localparam logic [SCALE_W-1:0] VSCALE_4 = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SINGLE,
      ST_MAP,
      ST_READ,
      ST_EMIT
   } seq_state_type;

   typedef struct packed {
      logic [CODE_W-1:0]  first_code;
      logic [CODE_W-1:0]  last_code;
      logic [CODE_W-1:0]  substitute_index;
      logic [CODE_W-1:0]  index_offset;
      logic [SCALE_W-1:0] horizontal_scale;
      logic [SCALE_W-1:0] vertical_scale;
   } cfg_type;

   // each of four bits becomes a pair
   function automatic logic [7:0] double_bits(input logic [3:0] v);
      logic [7:0] d;
      d = 8'h00;
      if (v[0]) d = d | 8'h03;
      if (v[1]) d = d | 8'h0C;
      if (v[2]) d = d | 8'h30;
      if (v[3]) d = d | 8'hC0;
      return d;
   endfunction

   function automatic logic [7:0] stretch_row(input logic [7:0] g,
                                              input logic [SCALE_W-1:0] vscale,
                                              input logic [ROW_W-1:0] row);
      logic [7:0] r;
      logic [3:0] nib;
      logic [7:0] sh;
      logic [7:0] d2;
      r = g;
      if (vscale == VSCALE_2) begin
         sh  = g >> {row, 2'b00};
         nib = sh[3:0];
         r   = double_bits(nib);
      end else if (vscale == VSCALE_4) begin
         sh  = g >> {row, 1'b0};
         nib = {2'b00, sh[1:0]};
         d2  = double_bits(nib);
         r   = double_bits(d2[3:0]);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sgcg_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sgcg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/sgcg_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sgcg_seq #(
   parameter int GLYPH_COLUMNS = 8,
   parameter int GLYPH_COUNT   = 256,
   parameter int MAX_HSCALE    = 4
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire sgcg_pkg::cfg_type             cfg,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_opcode,
   input  wire logic [sgcg_pkg::CODE_W-1:0]   req_char_code,
   input  wire logic [sgcg_pkg::ROW_W-1:0]    req_page_row,
   input  wire logic [sgcg_pkg::ADDR_W-1:0]   req_mem_address,
   input  wire logic [sgcg_pkg::BYTE_W-1:0]   req_mem_data,
   output logic                               ram_wr_en,
   output logic      [sgcg_pkg::ADDR_W-1:0]   ram_wr_addr,
   output logic      [sgcg_pkg::BYTE_W-1:0]   ram_wr_data,
   output logic                               ram_rd_en,
   output logic      [sgcg_pkg::ADDR_W-1:0]   ram_rd_addr,
   input  wire logic [sgcg_pkg::BYTE_W-1:0]   ram_rd_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic      [sgcg_pkg::BYTE_W-1:0]   rsp_column_byte,
   output logic                               rsp_last,
   output logic                               rsp_error
);
   import sgcg_pkg::*;

   localparam int COL_W = (GLYPH_COLUMNS > 1) ? $clog2(GLYPH_COLUMNS) : 1;
   localparam logic [COL_W-1:0] COL_LAST = COL_W'(GLYPH_COLUMNS - 1);

   // glyph index reduced modulo the glyph count
   logic [CODE_W-1:0] mod_tbl [256];
   for (genvar g = 0; g < 256; g++) begin : g_mod
      assign mod_tbl[g] = CODE_W'(g % GLYPH_COUNT);
   end

   seq_state_type state_ff, state_in;

   logic [CODE_W-1:0]  idx_ff, idx_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [SCALE_W-1:0] hs_ff, hs_in;
   logic               err_ff, err_in;
   logic [ADDR_W-1:0]  base_ff, base_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [SCALE_W-1:0] rep_ff, rep_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]  byte_ff, byte_in;
   logic               last_ff, last_in;
   logic               rerr_ff, rerr_in;

   logic               out_free;
   logic               vs_ok;
   logic               row_bad;
   logic               in_range;
   logic [CODE_W-1:0]  raw_idx;
   logic [SCALE_W-1:0] hs_clamped;
   logic [COL_W-1:0]   col_rd;
   logic               rep_done;
   logic               col_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      row_ff  <= row_in;
      hs_ff   <= hs_in;
      err_ff  <= err_in;
      base_ff <= base_in;
      col_ff  <= col_in;
      rep_ff  <= rep_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
      rerr_ff <= rerr_in;
   end

   always_comb begin
      out_free = !rsp_valid_ff || rsp_ready;
      vs_ok    = (cfg.vertical_scale == VSCALE_1) || (cfg.vertical_scale == VSCALE_2) ||
                 (cfg.vertical_scale == VSCALE_4);
      row_bad  = ({1'b0, req_page_row} >= cfg.vertical_scale);
      in_range = (req_char_code >= cfg.first_code) && (req_char_code <= cfg.last_code);
      raw_idx  = in_range ? CODE_W'(req_char_code + cfg.index_offset)
                          : cfg.substitute_index;
      if (cfg.horizontal_scale == '0) begin
         hs_clamped = SCALE_W'(1);
      end else if (int'(cfg.horizontal_scale) > MAX_HSCALE) begin
         hs_clamped = SCALE_W'(MAX_HSCALE);
      end else begin
         hs_clamped = cfg.horizontal_scale;
      end
      rep_done = (rep_ff == hs_ff - SCALE_W'(1));
      col_done = (col_ff == COL_LAST);

      state_in     = state_ff;
      idx_in       = idx_ff;
      row_in       = row_ff;
      hs_in        = hs_ff;
      err_in       = err_ff;
      base_in      = base_ff;
      col_in       = col_ff;
      rep_in       = rep_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      byte_in      = byte_ff;
      last_in      = last_ff;
      rerr_in      = rerr_ff;
      req_ready    = 1'b0;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;
      col_rd       = col_ff;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               row_in = req_page_row;
               idx_in = mod_tbl[raw_idx];
               hs_in  = hs_clamped;
               if (req_opcode == OP_WRITE) begin
                  ram_wr_en = 1'b1;
                  err_in    = 1'b0;
                  state_in  = ST_SINGLE;
               end else if (!vs_ok || row_bad) begin
                  err_in   = 1'b1;
                  state_in = ST_SINGLE;
               end else begin
                  err_in   = 1'b0;
                  state_in = ST_MAP;
               end
            end
         end
         ST_SINGLE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               byte_in      = '0;
               last_in      = 1'b1;
               rerr_in      = err_ff;
               state_in     = ST_IDLE;
            end
         end
         ST_MAP: begin
            base_in  = ADDR_W'({{(ADDR_W - CODE_W){1'b0}}, idx_ff} * ADDR_W'(GLYPH_COLUMNS));
            col_in   = '0;
            rep_in   = '0;
            state_in = ST_READ;
         end
         ST_READ: begin
            ram_rd_en = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               byte_in      = stretch_row(ram_rd_data, cfg.vertical_scale, row_ff);
               last_in      = rep_done && col_done;
               rerr_in      = 1'b0;
               if (rep_done) begin
                  rep_in = '0;
                  if (col_done) begin
                     state_in = ST_IDLE;
                  end else begin
                     // fetch the next column while this one goes out
                     col_rd    = col_ff + COL_W'(1);
                     col_in    = col_rd;
                     ram_rd_en = 1'b1;
                  end
               end else begin
                  rep_in = rep_ff + SCALE_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign ram_wr_addr     = req_mem_address;
   assign ram_wr_data     = req_mem_data;
   assign ram_rd_addr     = base_ff + ADDR_W'(col_rd);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_column_byte = byte_ff;
   assign rsp_last        = last_ff;
   assign rsp_error       = rerr_ff;

endmodule

`default_nettype wire

// ===== rtl/core/scaled_glyph_column_generator_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake             payload
// req       in         req_valid/req_ready   opcode, char_code, page_row, mem_address, mem_data
// rsp       out        rsp_valid/rsp_ready   column_byte, last, error
// csr       in         csr_write_enable      csr_index, csr_write_data
//
// one item at a time; req_ready is high only while the sequencer is idle
// write item or error: a single result, loaded into the output register from ST_SINGLE
// render item: GLYPH_COLUMNS * hscale results, one per cycle from the output register while
// rsp_ready allows, after ST_MAP and ST_READ; the sequencer is idle again once the last is loaded
// rsp_ready low holds the output register; the sequencer waits at its next result
// synchronous reset clears the control state and config; glyph ram is not cleared

module scaled_glyph_column_generator_unit #(
   parameter int GLYPH_COLUMNS = 8,
   parameter int GLYPH_COUNT   = 256,
   parameter int MAX_HSCALE    = 4
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // configuration writes
   input  wire logic                             csr_write_enable,
   input  wire logic [sgcg_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [sgcg_pkg::CODE_W-1:0]      csr_write_data,
   // request items
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic                             req_opcode,
   input  wire logic [sgcg_pkg::CODE_W-1:0]      req_char_code,
   input  wire logic [sgcg_pkg::ROW_W-1:0]       req_page_row,
   input  wire logic [sgcg_pkg::ADDR_W-1:0]      req_mem_address,
   input  wire logic [sgcg_pkg::BYTE_W-1:0]      req_mem_data,
   // result items
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic      [sgcg_pkg::BYTE_W-1:0]      rsp_column_byte,
   output logic                                  rsp_last,
   output logic                                  rsp_error
);
   import sgcg_pkg::*;

   cfg_type cfg_ff, cfg_in;

   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [BYTE_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [BYTE_W-1:0] ram_rd_data;

   // config register file, unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            REG_FIRST_CODE:  cfg_in.first_code       = csr_write_data;
            REG_LAST_CODE:   cfg_in.last_code        = csr_write_data;
            REG_SUBST_INDEX: cfg_in.substitute_index = csr_write_data;
            REG_INDEX_OFFS:  cfg_in.index_offset     = csr_write_data;
            REG_HSCALE:      cfg_in.horizontal_scale = csr_write_data[SCALE_W-1:0];
            REG_VSCALE:      cfg_in.vertical_scale   = csr_write_data[SCALE_W-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.first_code       <= RST_FIRST_CODE;
         cfg_ff.last_code        <= RST_LAST_CODE;
         cfg_ff.substitute_index <= RST_SUBST_INDEX;
         cfg_ff.index_offset     <= RST_INDEX_OFFS;
         cfg_ff.horizontal_scale <= RST_HSCALE;
         cfg_ff.vertical_scale   <= RST_VSCALE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // sequencer: maps the code, walks columns and repeats, owns the output register
   sgcg_seq #(
      .GLYPH_COLUMNS (GLYPH_COLUMNS),
      .GLYPH_COUNT   (GLYPH_COUNT),
      .MAX_HSCALE    (MAX_HSCALE)
   ) u_seq (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_char_code   (req_char_code),
      .req_page_row    (req_page_row),
      .req_mem_address (req_mem_address),
      .req_mem_data    (req_mem_data),
      .ram_wr_en       (ram_wr_en),
      .ram_wr_addr     (ram_wr_addr),
      .ram_wr_data     (ram_wr_data),
      .ram_rd_en       (ram_rd_en),
      .ram_rd_addr     (ram_rd_addr),
      .ram_rd_data     (ram_rd_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_column_byte (rsp_column_byte),
      .rsp_last        (rsp_last),
      .rsp_error       (rsp_error)
   );

   // glyph store, one column byte per entry
   sgcg_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (STORE_DEPTH)
   ) u_glyph_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

`default_nettype wire

// ===== bench/scaled_glyph_column_generator_unit_test.sv =====
`timescale 1ns / 1ps

module scaled_glyph_column_generator_unit_test;
   import sgcg_pkg::*;

   localparam int GLYPH_COLS        = 8;
   localparam int GLYPHS            = 256;
   localparam int HSCALE_MAX        = 4;
   localparam int IDLE_LIMIT        = 4000;   // cycles with no handshake at all
   localparam int DRAIN_CYCLES      = 40;
   localparam int ITEMS_PER_SETTING = 30;
   localparam int PRINT_CAP         = 40;

   // vertical scales the block must reject
   localparam logic [SCALE_W-1:0] VSCALE_BAD_0 = 3'd0;
   localparam logic [SCALE_W-1:0] VSCALE_BAD_3 = 3'd3;
   localparam logic [SCALE_W-1:0] VSCALE_BAD_7 = 3'd7;

   typedef struct packed {
      logic              opcode;
      logic [CODE_W-1:0] char_code;
      logic [ROW_W-1:0]  page_row;
      logic [ADDR_W-1:0] mem_address;
      logic [BYTE_W-1:0] mem_data;
   } glyph_req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] column_byte;
      logic              last;
      logic              error;
   } column_rsp_type;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_COIN,
      READY_SPARSE,
      READY_PERIODIC
   } ready_mode_type;

   logic                 clock            = 1'b0;
   logic                 reset            = 1'b1;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index        = '0;
   logic [CODE_W-1:0]    csr_write_data   = '0;
   logic                 req_valid        = 1'b0;
   glyph_req_type        req_item         = '0;
   logic                 rsp_ready        = 1'b0;
   wire                  req_ready;
   wire                  rsp_valid;
   wire  [BYTE_W-1:0]    rsp_column_byte;
   wire                  rsp_last;
   wire                  rsp_error;

   scaled_glyph_column_generator_unit #(
      .GLYPH_COLUMNS (GLYPH_COLS),
      .GLYPH_COUNT   (GLYPHS),
      .MAX_HSCALE    (HSCALE_MAX)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_item.opcode),
      .req_char_code    (req_item.char_code),
      .req_page_row     (req_item.page_row),
      .req_mem_address  (req_item.mem_address),
      .req_mem_data     (req_item.mem_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_column_byte  (rsp_column_byte),
      .rsp_last         (rsp_last),
      .rsp_error        (rsp_error)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // item source and expected column stream
   glyph_req_type  request_queue[$];
   column_rsp_type expected_columns[$];

   // shadow of the glyph memory (updated in accept order) and of the registers
   logic [BYTE_W-1:0] glyph_shadow [STORE_DEPTH];
   cfg_type           shadow_cfg;

   // which glyph bytes the stimulus has written so far (generation side)
   bit glyph_loaded [STORE_DEPTH];

   int queued_items    = 0;
   int req_issued      = 0;
   int req_accepts     = 0;
   int mismatches      = 0;
   int results_checked = 0;
   int render_items    = 0;
   int write_items     = 0;
   int error_results   = 0;
   int settings_run    = 0;
   int idle_cycles     = 0;
   int burst_left      = 0;
   int gap_left        = 0;
   int stall_left      = 0;
   int stall_tick      = 0;
   ready_mode_type stall_mode = READY_ALWAYS;

   // glyph index lookup: out-of-range codes take the substitute glyph,
   // the rest are offset with 8-bit wrap
   function automatic logic [7:0] glyph_index(input logic [CODE_W-1:0] code);
      logic [7:0] sum;
      if (code < shadow_cfg.first_code || code > shadow_cfg.last_code)
         return shadow_cfg.substitute_index;
      sum = code + shadow_cfg.index_offset;
      return sum;
   endfunction

   // true when the scale is legal and the row lies inside the stretched glyph
   function automatic bit row_renders(input logic [ROW_W-1:0] row);
      logic [SCALE_W-1:0] vs;
      vs = shadow_cfg.vertical_scale;
      if (vs != VSCALE_1 && vs != VSCALE_2 && vs != VSCALE_4)
         return 1'b0;
      return row < vs;
   endfunction

   function automatic bit glyph_ready(input logic [7:0] idx);
      bit ok;
      ok = 1'b1;
      for (int c = 0; c < GLYPH_COLS; c++)
         if (!glyph_loaded[idx * GLYPH_COLS + c]) ok = 1'b0;
      return ok;
   endfunction

   // expected column stream for one accepted item
   task automatic predict_glyph_columns(input glyph_req_type it);
      column_rsp_type r;
      logic [7:0]  idx;
      logic [7:0]  g;
      logic [7:0]  b;
      int          reps;
      int          vs;
      int          col;
      int          rep;
      int          k;
      r = '0;
      if (it.opcode == OP_WRITE) begin
         write_items++;
         glyph_shadow[it.mem_address] = it.mem_data;
         r.last = 1'b1;
         expected_columns.push_back(r);
      end else if (!row_renders(it.page_row)) begin
         render_items++;
         r.last  = 1'b1;
         r.error = 1'b1;
         expected_columns.push_back(r);
      end else begin
         render_items++;
         idx  = glyph_index(it.char_code);
         reps = int'(shadow_cfg.horizontal_scale);
         if (reps < 1) reps = 1;
         if (reps > HSCALE_MAX) reps = HSCALE_MAX;
         vs = int'(shadow_cfg.vertical_scale);
         for (col = 0; col < GLYPH_COLS; col++) begin
            g = glyph_shadow[(idx * GLYPH_COLS + col) % STORE_DEPTH];
            // output pixel k of stretched row r comes from source pixel (8r + k) / scale
            for (k = 0; k < 8; k++)
               b[k] = g[(8 * int'(it.page_row) + k) / vs];
            for (rep = 0; rep < reps; rep++) begin
               r.column_byte = b;
               r.last        = (col == GLYPH_COLS - 1) && (rep == reps - 1);
               r.error       = 1'b0;
               expected_columns.push_back(r);
            end
         end
      end
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatches++;
      if (mismatches <= PRINT_CAP)
         $display("%0t: result %0d %s: got %0d, expected %0d",
                  $time, results_checked, what, got, want);
   endtask

   // ---------------------------------------------------------------------
   // stimulus helpers, all run from the main sequence
   // ---------------------------------------------------------------------

   task automatic queue_write(input logic [ADDR_W-1:0] addr, input logic [BYTE_W-1:0] data);
      glyph_req_type it;
      it.opcode      = OP_WRITE;
      it.char_code   = CODE_W'($urandom_range(0, 255));
      it.page_row    = ROW_W'($urandom_range(0, 3));
      it.mem_address = addr;
      it.mem_data    = data;
      glyph_loaded[addr] = 1'b1;
      request_queue.push_back(it);
      queued_items++;
   endtask

   // a render that would read memory is preceded by the glyph's eight bytes
   // whenever any of them has not been written yet
   task automatic queue_render(input logic [CODE_W-1:0] code, input logic [ROW_W-1:0] row);
      glyph_req_type it;
      logic [7:0] idx;
      idx = glyph_index(code);
      if (row_renders(row) && !glyph_ready(idx))
         for (int c = 0; c < GLYPH_COLS; c++)
            queue_write(ADDR_W'(idx * GLYPH_COLS + c), BYTE_W'($urandom_range(0, 255)));
      it.opcode      = OP_RENDER;
      it.char_code   = code;
      it.page_row    = row;
      it.mem_address = ADDR_W'($urandom_range(0, STORE_DEPTH - 1));
      it.mem_data    = BYTE_W'($urandom_range(0, 255));
      request_queue.push_back(it);
      queued_items++;
   endtask

   // mostly codes whose glyph is already loaded, now and then any code
   function automatic logic [CODE_W-1:0] pick_code();
      logic [CODE_W-1:0] c;
      c = CODE_W'($urandom_range(0, 255));
      if ($urandom_range(0, 99) < 15)
         return c;
      for (int t = 0; t < 16; t++) begin
         if (glyph_ready(glyph_index(c)))
            return c;
         c = CODE_W'($urandom_range(0, 255));
      end
      return c;
   endfunction

   // mostly legal rows, some beyond the stretched height
   function automatic logic [ROW_W-1:0] pick_row();
      int vs;
      vs = int'(shadow_cfg.vertical_scale);
      if (!row_renders('0) || $urandom_range(0, 99) < 15)
         return ROW_W'($urandom_range(0, 3));
      return ROW_W'($urandom_range(0, vs - 1));
   endfunction

   task automatic queue_random(input int count);
      int start;
      start = queued_items;
      while (queued_items - start < count) begin
         if ($urandom_range(0, 99) < 15)
            queue_write(ADDR_W'($urandom_range(0, STORE_DEPTH - 1)),
                        BYTE_W'($urandom_range(0, 255)));
         else
            queue_render(pick_code(), pick_row());
      end
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx, input logic [CODE_W-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      case (idx)
         REG_FIRST_CODE:  shadow_cfg.first_code       = value;
         REG_LAST_CODE:   shadow_cfg.last_code        = value;
         REG_SUBST_INDEX: shadow_cfg.substitute_index = value;
         REG_INDEX_OFFS:  shadow_cfg.index_offset     = value;
         REG_HSCALE:      shadow_cfg.horizontal_scale = value[SCALE_W-1:0];
         REG_VSCALE:      shadow_cfg.vertical_scale   = value[SCALE_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // only called with the block idle
   task automatic run_setting(input logic [CODE_W-1:0] first, input logic [CODE_W-1:0] lastc,
                              input logic [CODE_W-1:0] subst, input logic [CODE_W-1:0] offs,
                              input logic [SCALE_W-1:0] hs, input logic [SCALE_W-1:0] vs);
      write_register(REG_FIRST_CODE, first);
      write_register(REG_LAST_CODE, lastc);
      write_register(REG_SUBST_INDEX, subst);
      write_register(REG_INDEX_OFFS, offs);
      write_register(REG_HSCALE, CODE_W'(hs));
      write_register(REG_VSCALE, CODE_W'(vs));
      settings_run++;
      @(posedge clock);
      // code range edges under this setting
      queue_render('0, pick_row());
      queue_render('1, pick_row());
      queue_render(first, pick_row());
      queue_render(lastc, pick_row());
      queue_random(ITEMS_PER_SETTING);
      wait_for_drain();
   endtask

   // sender holds off here until every expected column has come back
   task automatic wait_for_drain();
      do
         @(posedge clock);
      while (request_queue.size() != 0 || req_valid || expected_columns.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // driver: bursts of items with random gaps, payload changes on falling edge
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      logic          next_valid;
      glyph_req_type next_item;
      next_valid = req_valid;
      next_item  = req_item;
      if (reset) begin
         next_valid = 1'b0;
      end else if (!req_valid || req_accepts == req_issued) begin
         // previous item taken (or none was up)
         if (gap_left > 0) begin
            gap_left--;
            next_valid = 1'b0;
         end else if (request_queue.size() != 0) begin
            next_item  = request_queue.pop_front();
            next_valid = 1'b1;
            req_issued++;
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 16);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
         end else begin
            next_valid = 1'b0;
         end
      end
      req_valid <= next_valid;
      req_item  <= next_item;
   end

   // request handshake: predict at the accepting edge
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         predict_glyph_columns(req_item);
         req_accepts++;
      end
   end

   // receiver backpressure, mode picked afresh whenever the stall counter runs out
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = ready_mode_type'($urandom_range(0, 3));
         stall_left = $urandom_range(16, 96);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         READY_ALWAYS:   rsp_ready <= 1'b1;
         READY_COIN:     rsp_ready <= 1'($urandom_range(0, 1));
         READY_SPARSE:   rsp_ready <= ($urandom_range(0, 7) == 0);
         default:        rsp_ready <= (stall_tick % 4 == 0);
      endcase
      stall_tick++;
   end

   // monitor: each accepted column against the oldest expectation
   always @(posedge clock) begin
      column_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_checked++;
         if (rsp_error) error_results++;
         if (expected_columns.size() == 0) begin
            report_mismatch("with nothing expected, column_byte", rsp_column_byte, -1);
         end else begin
            want = expected_columns.pop_front();
            if (rsp_column_byte !== want.column_byte)
               report_mismatch("column_byte", rsp_column_byte, want.column_byte);
            if (rsp_last !== want.last)
               report_mismatch("last", rsp_last, want.last);
            if (rsp_error !== want.error)
               report_mismatch("error", rsp_error, want.error);
         end
      end
   end

   // watchdog on cycles with no handshake on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------
   initial begin
      logic [SCALE_W-1:0] rand_vs;
      shadow_cfg.first_code       = RST_FIRST_CODE;
      shadow_cfg.last_code        = RST_LAST_CODE;
      shadow_cfg.substitute_index = RST_SUBST_INDEX;
      shadow_cfg.index_offset     = RST_INDEX_OFFS;
      shadow_cfg.horizontal_scale = RST_HSCALE;
      shadow_cfg.vertical_scale   = RST_VSCALE;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed items under reset configuration
      queue_write('0, 8'hFF);
      queue_write(ADDR_W'(STORE_DEPTH - 1), 8'h00);
      queue_write(11'h555, 8'hAA);
      queue_write(11'h2AA, 8'h55);
      queue_render(8'd0, 2'd0);     // below range, substitute glyph
      queue_render(8'd31, 2'd0);
      queue_render(8'd32, 2'd0);    // first in-range code, offset wraps
      queue_render(8'd126, 2'd0);   // last in-range code
      queue_render(8'd127, 2'd0);   // just above range
      queue_render(8'd255, 2'd0);
      queue_render(8'd65, 2'd1);    // row beyond unscaled glyph
      queue_render(8'd65, 2'd3);
      queue_write(ADDR_W'(STORE_DEPTH - 1), 8'hA5);
      queue_render(8'd200, 2'd0);
      queue_random(ITEMS_PER_SETTING);
      wait_for_drain();
      settings_run++;

      // full code range, double height, last glyph reachable
      run_setting(8'd0,   8'd255, 8'd255, 8'd0,   3'd2, VSCALE_2);
      // empty range: every code takes the substitute glyph
      run_setting(8'd255, 8'd0,   8'd17,  8'd255, 3'd4, VSCALE_4);
      // horizontal scale zero acts as one
      run_setting(8'd48,  8'd57,  8'd200, 8'd128, 3'd0, VSCALE_4);
      // horizontal scale above the maximum is clamped
      run_setting(8'd10,  8'd200, 8'd3,   8'd1,   3'd7, VSCALE_2);
      // illegal vertical scales give an error item per render
      run_setting(8'd0,   8'd255, 8'd128, 8'd64,  3'd3, VSCALE_BAD_3);
      run_setting(8'd65,  8'd90,  8'd255, 8'd190, 3'd1, VSCALE_BAD_0);
      run_setting(8'd32,  8'd126, 8'd0,   8'd225, 3'd3, VSCALE_BAD_7);
      // single-code range
      run_setting(8'd100, 8'd100, 8'd42,  8'd7,   3'd4, VSCALE_1);
      // random settings with a legal vertical scale
      repeat (2) begin
         case ($urandom_range(0, 2))
            0:       rand_vs = VSCALE_1;
            1:       rand_vs = VSCALE_2;
            default: rand_vs = VSCALE_4;
         endcase
         run_setting(CODE_W'($urandom_range(0, 255)), CODE_W'($urandom_range(0, 255)),
                     CODE_W'($urandom_range(0, 255)), CODE_W'($urandom_range(0, 255)),
                     SCALE_W'($urandom_range(0, 7)), rand_vs);
      end

      $display("ran %0d register settings: %0d write items, %0d render items",
               settings_run, write_items, render_items);
      $display("checked %0d column items (%0d flagged error), %0d mismatches",
               results_checked, error_results, mismatches);
      if (mismatches == 0 && expected_columns.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/sgcg_pkg.sv
rtl/core/sgcg_ram.sv
rtl/core/sgcg_seq.sv
rtl/core/scaled_glyph_column_generator_unit.sv
bench/scaled_glyph_column_generator_unit_test.sv
